// File: rtl/kmd_pkg.sv
// Shared types, codes and defaults for the key matrix debounce block.
// Used by every module under rtl/ except kmd_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package kmd_pkg;

  // Default geometry and reset values
  localparam int ROWS_DEF        = 8;
  localparam int COLS_DEF        = 8;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;

  // Request type codes on the request channel
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  row_index;
    logic [7:0]  column_bits;
    logic [2:0]  key_column;
    logic [31:0] now_ms;
  } kmd_in_t;

  typedef struct packed {
    logic        event_valid;
    logic [2:0]  event_row;
    logic [2:0]  event_col;
    logic [5:0]  event_key_index;
    logic        event_pressed;
    logic [31:0] event_time;
    logic        key_pressed;
    logic        row_changed;
    logic [3:0]  dropped_events;
    logic [5:0]  queue_fill;
  } kmd_out_t;

  // One stored event (key index is rebuilt on the way out)
  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic        pressed;
    logic [31:0] stamp;
  } kmd_entry_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TICK,
    OP_POP,
    OP_QUERY
  } kmd_op_t;

  // Classified request handed from front to engine
  typedef struct packed {
    kmd_op_t     op;
    logic        row_ok;
    logic        col_ok;
    logic [2:0]  row;
    logic [7:0]  bits;
    logic [2:0]  kcol;
    logic [31:0] now;
  } kmd_cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_FIN,
    ENG_READ,
    ENG_TICK
  } kmd_state_t;

endpackage
`default_nettype wire

// File: rtl/kmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/kmd_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on kmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kmd_front #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire kmd_pkg::kmd_in_t req_data,
  output logic                  cmd_valid,
  output kmd_pkg::kmd_cmd_t     cmd,
  input  wire logic             take
);

  logic [1:0]        fill;
  logic              wr_sel;
  logic              rd_sel;
  kmd_pkg::kmd_cmd_t slot [2];
  kmd_pkg::kmd_cmd_t cmd_new;
  logic              push;

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_sel];

  // Decode request type and range-check row and column
  always_comb begin
    cmd_new.row    = req_data.row_index;
    cmd_new.bits   = req_data.column_bits;
    cmd_new.kcol   = req_data.key_column;
    cmd_new.now    = req_data.now_ms;
    cmd_new.row_ok = (int'(req_data.row_index) < ROWS);
    cmd_new.col_ok = (int'(req_data.key_column) < COLS);
    case (req_data.req_type)
      kmd_pkg::REQ_SAMPLE: cmd_new.op = kmd_pkg::OP_SAMPLE;
      kmd_pkg::REQ_TICK:   cmd_new.op = kmd_pkg::OP_TICK;
      kmd_pkg::REQ_POP:    cmd_new.op = kmd_pkg::OP_POP;
      default:             cmd_new.op = kmd_pkg::OP_QUERY;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= cmd_new;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
    end else begin
      if (push) begin
        wr_sel <= !wr_sel;
      end
      if (take) begin
        rd_sel <= !rd_sel;
      end
      case ({push, take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/kmd_engine.sv
// Back end: key debounce state, event queue control and the result register.
// Depends on kmd_pkg and kmd_ram.
`timescale 1ns / 1ps
`default_nettype none
module kmd_engine #(
  parameter int ROWS        = kmd_pkg::ROWS_DEF,
  parameter int COLS        = kmd_pkg::COLS_DEF,
  parameter int QUEUE_DEPTH = kmd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              cmd_valid,
  input  wire kmd_pkg::kmd_cmd_t cmd,
  output logic                   take,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output kmd_pkg::kmd_out_t      rsp_data
);

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW    = $clog2(QUEUE_DEPTH + 1);
  localparam int EW    = $bits(kmd_pkg::kmd_entry_t);

  kmd_pkg::kmd_state_t state;
  kmd_pkg::kmd_state_t state_next;
  logic [7:0]          dticks;

  // Per-key debounce state, one word per row
  logic [COLS-1:0]      deb  [ROWS];
  logic [COLS-1:0]      stab [ROWS];
  logic [COLS-1:0]      pend [ROWS];
  logic [COLS-1:0][7:0] cnt  [ROWS];

  // Current row sample
  logic [2:0]    cur_row;
  logic [7:0]    cur_bits;
  logic [31:0]   cur_now;
  logic [CW-1:0] col;
  logic [RW-1:0] trow;
  logic          changed;
  logic [3:0]    dropped;

  // Event queue control
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          full;

  // Result register
  logic              out_valid;
  kmd_pkg::kmd_out_t out_data;

  // Control from the output decode
  logic              scan_step;
  logic              pop_issue;
  logic              tick_step;
  logic              load_out;
  kmd_pkg::kmd_out_t res;

  // Scan datapath for the key under the column counter
  logic [RW-1:0] kr;
  logic          raw;
  logic          nd;
  logic          ns;
  logic          np;
  logic [7:0]    nc;
  logic          hit;

  kmd_pkg::kmd_entry_t wr_entry;
  kmd_pkg::kmd_entry_t rd_entry;
  logic [EW-1:0]       rd_word;
  logic                ram_we;

  assign full      = (count == NW'(QUEUE_DEPTH));
  assign rsp_valid = out_valid;
  assign rsp_data  = out_data;
  assign rd_entry  = kmd_pkg::kmd_entry_t'(rd_word);
  assign kr        = RW'(cur_row);

  // Debounce decision for one key
  always_comb begin
    raw = cur_bits[3'(col)];
    nd  = deb[kr][col];
    ns  = stab[kr][col];
    np  = pend[kr][col];
    nc  = cnt[kr][col];
    hit = 1'b0;
    if (!deb[kr][col]) begin
      if (raw != stab[kr][col]) begin
        nd = 1'b1;
        np = raw;
        nc = dticks;
      end
    end else if (raw == stab[kr][col]) begin
      nd = 1'b0;
      nc = 8'd0;
    end else if (cnt[kr][col] == 8'd0) begin
      if (raw == pend[kr][col]) begin
        ns  = raw;
        nd  = 1'b0;
        hit = 1'b1;
      end else begin
        np = raw;
        nc = dticks;
      end
    end else if (raw != pend[kr][col]) begin
      np = raw;
      nc = dticks;
    end
  end

  assign ram_we         = scan_step && hit && !full;
  assign wr_entry.row   = cur_row;
  assign wr_entry.col   = 3'(col);
  assign wr_entry.pressed = raw;
  assign wr_entry.stamp = cur_now;

  kmd_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (wr_entry),
    .raddr (rd_ptr),
    .rdata (rd_word)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kmd_pkg::ENG_IDLE: begin
        if (cmd_valid && !out_valid) begin
          if (cmd.op == kmd_pkg::OP_SAMPLE && cmd.row_ok) begin
            state_next = kmd_pkg::ENG_SCAN;
          end else if (cmd.op == kmd_pkg::OP_TICK) begin
            state_next = kmd_pkg::ENG_TICK;
          end else if (cmd.op == kmd_pkg::OP_POP && count != '0) begin
            state_next = kmd_pkg::ENG_READ;
          end
        end
      end
      kmd_pkg::ENG_SCAN: begin
        if (int'(col) == COLS - 1) begin
          state_next = kmd_pkg::ENG_FIN;
        end
      end
      kmd_pkg::ENG_TICK: begin
        if (int'(trow) == ROWS - 1) begin
          state_next = kmd_pkg::ENG_IDLE;
        end
      end
      kmd_pkg::ENG_FIN:  state_next = kmd_pkg::ENG_IDLE;
      kmd_pkg::ENG_READ: state_next = kmd_pkg::ENG_IDLE;
      default:           state_next = kmd_pkg::ENG_IDLE;
    endcase
  end

  // Outputs per state
  always_comb begin
    take      = 1'b0;
    scan_step = 1'b0;
    pop_issue = 1'b0;
    tick_step = 1'b0;
    load_out  = 1'b0;
    res       = '0;
    res.queue_fill = 6'(count);
    case (state)
      kmd_pkg::ENG_IDLE: begin
        if (cmd_valid && !out_valid) begin
          take = 1'b1;
          case (cmd.op)
            kmd_pkg::OP_SAMPLE: load_out = !cmd.row_ok;
            kmd_pkg::OP_TICK:   ;
            kmd_pkg::OP_POP: begin
              pop_issue = (count != '0);
              load_out  = (count == '0);
            end
            default: begin
              load_out = 1'b1;
              res.key_pressed = (cmd.row_ok && cmd.col_ok) ?
                                stab[RW'(cmd.row)][CW'(cmd.kcol)] : 1'b0;
            end
          endcase
        end
      end
      kmd_pkg::ENG_SCAN: scan_step = 1'b1;
      // one row of countdowns per cycle; result goes out with the last row
      kmd_pkg::ENG_TICK: begin
        tick_step = 1'b1;
        load_out  = (int'(trow) == ROWS - 1);
      end
      kmd_pkg::ENG_FIN: begin
        load_out           = 1'b1;
        res.row_changed    = changed;
        res.dropped_events = dropped;
      end
      kmd_pkg::ENG_READ: begin
        load_out            = 1'b1;
        res.event_valid     = 1'b1;
        res.event_row       = rd_entry.row;
        res.event_col       = rd_entry.col;
        res.event_key_index = 6'(int'(rd_entry.row) * COLS + int'(rd_entry.col));
        res.event_pressed   = rd_entry.pressed;
        res.event_time      = rd_entry.stamp;
      end
      default: ;
    endcase
  end

  // State and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kmd_pkg::ENG_IDLE;
      dticks <= kmd_pkg::DEBOUNCE_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        dticks <= cfg_wdata;
      end
    end
  end

  // Key state: tick walks one row per cycle, scan updates one key
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        deb[r]  <= '0;
        stab[r] <= '0;
        pend[r] <= '0;
        cnt[r]  <= '0;
      end
    end else if (tick_step) begin
      for (int c = 0; c < COLS; c++) begin
        if (deb[trow][c] && cnt[trow][c] != 8'd0) begin
          cnt[trow][c] <= cnt[trow][c] - 8'd1;
        end
      end
    end else if (scan_step) begin
      deb[kr][col]  <= nd;
      stab[kr][col] <= ns;
      pend[kr][col] <= np;
      cnt[kr][col]  <= nc;
    end
  end

  // Sample latch (payload)
  always_ff @(posedge clk) begin
    if (take && cmd.op == kmd_pkg::OP_SAMPLE) begin
      cur_row  <= cmd.row;
      cur_bits <= cmd.bits;
      cur_now  <= cmd.now;
    end
  end

  // Column and row walks and per-sample totals
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      trow    <= '0;
      changed <= 1'b0;
      dropped <= 4'd0;
    end else if (take) begin
      col     <= '0;
      trow    <= '0;
      changed <= 1'b0;
      dropped <= 4'd0;
    end else if (scan_step) begin
      col <= col + CW'(1);
      if (hit) begin
        changed <= 1'b1;
        if (full) begin
          dropped <= dropped + 4'd1;
        end
      end
    end else if (tick_step) begin
      trow <= trow + RW'(1);
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (ram_we) begin
      wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      count  <= count + NW'(1);
    end else if (pop_issue) begin
      rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count  <= count - NW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !rsp_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// File: rtl/key_matrix_debounce_event_queue_core.sv
// Top level of the key matrix debouncer with event queue.
// Depends on kmd_pkg, kmd_front, kmd_engine and kmd_ram.
//
// channel | signals                       | direction | handshake
// req     | req_valid req_stall req_data  | in        | valid/stall, kmd_in_t
// rsp     | rsp_valid rsp_stall rsp_data  | out       | valid/stall, kmd_out_t
// cfg     | cfg_we cfg_wdata              | in        | write enable, debounce ticks
//
// A row sample walks one key per cycle through debounce update and queue write,
// then ENG_FIN loads the result. A tick walks one row of countdowns per cycle and
// loads the result with the last row. Pop issues the registered store read and
// ENG_READ loads the result; query loads its result straight from idle. A request
// passes through the two-entry front queue. Reset is synchronous and clears all
// key state and queue pointers; the event store is not cleared. A stalled response
// holds the engine, while the front queue keeps taking requests until full.
`timescale 1ns / 1ps
`default_nettype none
module key_matrix_debounce_event_queue_core #(
  parameter int ROWS        = kmd_pkg::ROWS_DEF,
  parameter int COLS        = kmd_pkg::COLS_DEF,
  parameter int QUEUE_DEPTH = kmd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire kmd_pkg::kmd_in_t  req_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output kmd_pkg::kmd_out_t      rsp_data,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata
);

  logic              cmd_valid;
  kmd_pkg::kmd_cmd_t cmd;
  logic              take;

  kmd_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take)
  );

  kmd_engine #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire

// File: dv/kmd_checker.sv
// Checker for the key matrix debouncer: watches both channels, predicts each
// response from its own key and queue state, and counts mismatches.
// Depends on kmd_pkg.
`timescale 1ns / 1ps
module kmd_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  kmd_pkg::kmd_in_t  req_data,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  kmd_pkg::kmd_out_t rsp_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                responses_seen,
  output int                events_confirmed
);

  localparam int NROWS  = 8;
  localparam int NCOLS  = 8;
  localparam int NKEYS  = NROWS * NCOLS;
  localparam int QDEPTH = 32;

  // predicted key and queue state
  logic [7:0]           ticks_cfg;
  logic                 deb    [NKEYS];
  logic [7:0]           cnt    [NKEYS];
  logic                 stable [NKEYS];
  logic                 pend   [NKEYS];
  kmd_pkg::kmd_entry_t  evq    [$];
  kmd_pkg::kmd_out_t    expected_rsp [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic kmd_pkg::kmd_out_t predict_response(input kmd_pkg::kmd_in_t r);
    kmd_pkg::kmd_out_t   o;
    kmd_pkg::kmd_entry_t e;
    int                  k;
    logic                raw;
    o = '0;
    case (r.req_type)
      kmd_pkg::REQ_SAMPLE: begin
        for (int c = 0; c < NCOLS; c++) begin
          k   = r.row_index * NCOLS + c;
          raw = r.column_bits[c];
          if (!deb[k]) begin
            if (raw != stable[k]) begin
              deb[k] = 1'b1; pend[k] = raw; cnt[k] = ticks_cfg;
            end
          end else if (raw == stable[k]) begin
            deb[k] = 1'b0; cnt[k] = '0;
          end else if (cnt[k] == 0) begin
            if (raw == pend[k]) begin
              stable[k] = raw; deb[k] = 1'b0; o.row_changed = 1'b1;
              events_confirmed++;
              if (evq.size() >= QDEPTH) o.dropped_events++;
              else begin
                e.row = r.row_index; e.col = 3'(c); e.pressed = raw; e.stamp = r.now_ms;
                evq.push_back(e);
              end
            end else begin
              pend[k] = raw; cnt[k] = ticks_cfg;
            end
          end else if (raw != pend[k]) begin
            pend[k] = raw; cnt[k] = ticks_cfg;
          end
        end
      end
      kmd_pkg::REQ_TICK: begin
        for (int i = 0; i < NKEYS; i++)
          if (deb[i] && cnt[i] != 0) cnt[i]--;
      end
      kmd_pkg::REQ_POP: begin
        if (evq.size() > 0) begin
          e = evq.pop_front();
          o.event_valid     = 1'b1;
          o.event_row       = e.row;
          o.event_col       = e.col;
          o.event_key_index = {e.row, e.col};
          o.event_pressed   = e.pressed;
          o.event_time      = e.stamp;
        end
      end
      default: o.key_pressed = stable[r.row_index * NCOLS + r.key_column];
    endcase
    o.queue_fill = 6'(evq.size());
    return o;
  endfunction

  always @(posedge clk) begin
    kmd_pkg::kmd_out_t w;
    if (rst) begin
      ticks_cfg = kmd_pkg::DEBOUNCE_RESET;
      for (int i = 0; i < NKEYS; i++) begin
        deb[i] = 0; cnt[i] = 0; stable[i] = 0; pend[i] = 0;
      end
      evq.delete();
      expected_rsp.delete();
      fail_count = 0; responses_seen = 0; events_confirmed = 0;
    end else begin
      if (cfg_we) ticks_cfg = cfg_wdata;
      if (req_valid && !req_stall) expected_rsp.push_back(predict_response(req_data));
      if (rsp_valid && !rsp_stall) begin
        responses_seen++;
        if (expected_rsp.size() == 0) report_mismatch("unexpected response", rsp_data, 0);
        else begin
          w = expected_rsp.pop_front();
          if (rsp_data.event_valid !== w.event_valid)
            report_mismatch("event_valid", rsp_data.event_valid, w.event_valid);
          if (rsp_data.event_row !== w.event_row)
            report_mismatch("event_row", rsp_data.event_row, w.event_row);
          if (rsp_data.event_col !== w.event_col)
            report_mismatch("event_col", rsp_data.event_col, w.event_col);
          if (rsp_data.event_key_index !== w.event_key_index)
            report_mismatch("event_key_index", rsp_data.event_key_index, w.event_key_index);
          if (rsp_data.event_pressed !== w.event_pressed)
            report_mismatch("event_pressed", rsp_data.event_pressed, w.event_pressed);
          if (rsp_data.event_time !== w.event_time)
            report_mismatch("event_time", rsp_data.event_time, w.event_time);
          if (rsp_data.key_pressed !== w.key_pressed)
            report_mismatch("key_pressed", rsp_data.key_pressed, w.key_pressed);
          if (rsp_data.row_changed !== w.row_changed)
            report_mismatch("row_changed", rsp_data.row_changed, w.row_changed);
          if (rsp_data.dropped_events !== w.dropped_events)
            report_mismatch("dropped_events", rsp_data.dropped_events, w.dropped_events);
          if (rsp_data.queue_fill !== w.queue_fill)
            report_mismatch("queue_fill", rsp_data.queue_fill, w.queue_fill);
        end
      end
    end
    pending = expected_rsp.size();
  end
endmodule

// File: dv/testbench.sv
// Top of the key matrix debouncer bench: clock, reset, request stimulus,
// register writes and the verdict. Depends on kmd_pkg, kmd_checker and the RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  kmd_pkg::kmd_in_t  req_data = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  kmd_pkg::kmd_out_t rsp_data;
  logic     cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int fail_count, pending, responses_seen, events_confirmed;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_rsp = 1'b0;
  int quiet_cycles = 0;
  int sent = 0;
  logic [7:0] row_level [8];
  logic [31:0] clock_ms = 0;

  always #10 clk = ~clk;

  key_matrix_debounce_event_queue_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  kmd_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending),
    .responses_seen(responses_seen), .events_confirmed(events_confirmed)
  );

  // receiver: random stall, or a forced hold-off
  always @(posedge clk)
    rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d responses outstanding", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one request, with optional idle gap first, and wait for acceptance
  task automatic send_request(input logic [1:0] op, input logic [2:0] row,
                              input logic [7:0] bits, input logic [2:0] col,
                              input logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid          <= 1'b1;
    req_data.req_type  <= op;
    req_data.row_index <= row;
    req_data.column_bits <= bits;
    req_data.key_column <= col;
    req_data.now_ms    <= stamp;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_and_write(input logic [7:0] ticks);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed key activity: hold each row level across ticks, with occasional changes
  task automatic random_request();
    int pick;
    logic [2:0] r;
    pick = $urandom_range(99);
    r = 3'($urandom_range(7));
    clock_ms = clock_ms + $urandom_range(1, 40);
    if (pick < 45) begin
      if ($urandom_range(3) == 0) row_level[r] = row_level[r] ^ 8'(1 << $urandom_range(7));
      if ($urandom_range(9) == 0) row_level[r] = 8'($urandom);
      send_request(kmd_pkg::REQ_SAMPLE, r, row_level[r], 3'($urandom), clock_ms);
    end else if (pick < 70)
      send_request(kmd_pkg::REQ_TICK, 3'($urandom), 8'($urandom), 3'($urandom), $urandom);
    else if (pick < 88)
      send_request(kmd_pkg::REQ_POP, 3'($urandom), 8'($urandom), 3'($urandom), $urandom);
    else
      send_request(kmd_pkg::REQ_QUERY, r, 8'($urandom), 3'($urandom), $urandom);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) row_level[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset ticks, press and confirm a row of keys, a cancelled bounce, all field extremes
    send_request(kmd_pkg::REQ_POP, 3'd7, 8'hFF, 3'd7, 32'hFFFFFFFF);
    send_request(kmd_pkg::REQ_QUERY, 3'd7, 8'h00, 3'd7, 32'h0);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd7, 8'hFF, 3'd0, 32'h0);
    repeat (5) send_request(kmd_pkg::REQ_TICK, 3'd0, 8'h00, 3'd0, 32'h0);
    send_request(kmd_pkg::REQ_TICK, 3'd0, 8'h00, 3'd0, 32'h0);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd7, 8'hFF, 3'd0, 32'hFFFFFFFF);
    send_request(kmd_pkg::REQ_QUERY, 3'd7, 8'h00, 3'd7, 32'h0);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd0, 8'h01, 3'd0, 32'h1);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd0, 8'h00, 3'd0, 32'h2);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd0, 8'h02, 3'd0, 32'h3);
    repeat (9) send_request(kmd_pkg::REQ_POP, 3'd0, 8'h00, 3'd0, 32'h0);

    // zero ticks: confirm on the following sample; then full queue drops
    drain_and_write(8'd0);
    for (int i = 0; i < 10; i++) begin
      send_request(kmd_pkg::REQ_SAMPLE, 3'(i % 8), 8'hFF, 3'd0, 32'(i));
      send_request(kmd_pkg::REQ_SAMPLE, 3'(i % 8), 8'hFF, 3'd0, 32'(i));
      send_request(kmd_pkg::REQ_SAMPLE, 3'(i % 8), 8'h00, 3'd0, 32'(i));
      send_request(kmd_pkg::REQ_SAMPLE, 3'(i % 8), 8'h00, 3'd0, 32'(i));
    end
    repeat (40) send_request(kmd_pkg::REQ_POP, 3'd0, 8'h00, 3'd0, 32'h0);

    // largest tick count: a few ticks only, so nothing confirms
    drain_and_write(8'd255);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd3, 8'hA5, 3'd0, 32'h5);
    repeat (4) send_request(kmd_pkg::REQ_TICK, 3'd0, 8'h00, 3'd0, 32'h0);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd3, 8'hA5, 3'd0, 32'h6);
    send_request(kmd_pkg::REQ_SAMPLE, 3'd3, 8'h00, 3'd0, 32'h7);

    // random phases over several settings and idling mixes
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_write(ph == 4 ? 8'd0 : 8'($urandom_range(1, 4)));
      case (ph)
        1: begin send_idle_pct = 47; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 47; end
        3: begin send_idle_pct = 13; stall_pct = 13; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 2) begin
        // receiver holds off while requests keep coming
        fork
          begin
            hold_rsp = 1'b1;
            repeat (150) @(posedge clk);
            hold_rsp = 1'b0;
          end
          repeat (30) random_request();
        join
      end
      repeat (85) random_request();
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("sent %0d requests, %0d responses, %0d confirmed key changes",
             sent, responses_seen, events_confirmed);
    $display("debounce settings 0, 1-4, 5 and 255; idle, stall and hold-off phases");
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
